// File: design/tlik_pkg.sv
package tlik_pkg;

	localparam int FRAC_BITS = 8;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_MAX = 24;
	localparam int ANG_BITS = 20;
	localparam int DIV_STEPS = 31;
	localparam int SQRT_STEPS = 31;
	localparam int REM_W = 38;
	localparam int ROOT_W = 62;
	localparam int XY_W = 34;
	localparam int ANG_W = 30;

	typedef enum logic [1:0] {
		REG_FIRST_LINK  = 2'd0,
		REG_SECOND_LINK = 2'd1,
		REG_THIRD_LINK  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [REM_W-1:0]     den;
		logic [DIV_STEPS-1:0] q;
		logic                 neg;
		logic                 sat;
	} div_t;

	typedef struct packed {
		logic [ROOT_W-1:0] n;
		logic [ROOT_W-1:0] res;
		logic signed [31:0] c;
	} sqrt_t;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ANG_W-1:0] ang;
	} cord_t;

	function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
		logic signed [ANG_W-1:0] v;
		case (i)
			0: v = 30'sd47185920;
			1: v = 30'sd27855475;
			2: v = 30'sd14718068;
			3: v = 30'sd7471121;
			4: v = 30'sd3750058;
			5: v = 30'sd1876857;
			6: v = 30'sd938658;
			7: v = 30'sd469357;
			8: v = 30'sd234682;
			9: v = 30'sd117342;
			10: v = 30'sd58671;
			11: v = 30'sd29335;
			12: v = 30'sd14668;
			13: v = 30'sd7334;
			14: v = 30'sd3667;
			15: v = 30'sd1833;
			16: v = 30'sd917;
			17: v = 30'sd458;
			18: v = 30'sd229;
			19: v = 30'sd115;
			20: v = 30'sd57;
			21: v = 30'sd29;
			22: v = 30'sd14;
			23: v = 30'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: design/three_link_planar_ik.sv
// Channel  | Valid      | Stall     | Beat fields
// input    | in_valid   | in_stall  | foot_radius, foot_angle
// output   | out_valid  | out_stall | hip_angle, knee_angle, ankle_angle, out_of_reach
// config   | cfg_we     | -         | cfg_index, cfg_data
//
// One beat enters per cycle unless in_stall is high; each beat passes through the
// 31 divider cells, the 31 square-root cells and the CORDIC cells in sequence.
// The whole pipeline advances together; it halts only while a result waits
// under out_stall, and in_stall is raised for exactly those cycles.
// Reset clears the link lengths and all valid bits.
module three_link_planar_ik import tlik_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        foot_radius,
	input  logic signed [16:0] foot_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] hip_angle,
	output logic [15:0]        knee_angle,
	output logic signed [18:0] ankle_angle,
	output logic               out_of_reach
);
	localparam int ST_DIV0 = 4;
	localparam int ST_A = ST_DIV0 + DIV_STEPS;
	localparam int ST_B = ST_A + 1;
	localparam int ST_SQ0 = ST_B + 1;
	localparam int ST_PREP = ST_SQ0 + SQRT_STEPS;
	localparam int ST_CORD0 = ST_PREP + 1;
	localparam int ST_E = ST_CORD0 + CORDIC_STAGES;
	localparam int NST = ST_E + 2;
	localparam int SIDE_LEN = ST_E + 1;

	localparam logic signed [18:0] HALF = 19'sd180 <<< FRAC_BITS;
	localparam logic signed [18:0] FULL = 19'sd360 <<< FRAC_BITS;
	localparam logic signed [18:0] TENTH = 19'(((1 << FRAC_BITS) + 5) / 10);
	localparam logic signed [18:0] RMIN = 19'sd10 <<< FRAC_BITS;
	localparam logic signed [ANG_W-1:0] TOP = ANG_W'(180) <<< ANG_BITS;
	localparam logic signed [ANG_W-1:0] RND = ANG_W'(1) <<< (ANG_BITS - 1 - FRAC_BITS);
	localparam logic [30:0] Q_ONE = 31'd1 << 30;

	typedef struct packed {
		logic signed [16:0] alpha;
		logic signed [16:0] phi;
		logic               flag;
	} side_t;

	logic [15:0] l1_q, l2_q, l3_q;
	logic        adv;
	logic [NST-1:0] v_q;
	side_t side_q [SIDE_LEN];

	logic [17:0]        rc_s1;
	logic [17:0]        a0_s2;
	logic [35:0]        a0sq_s3;
	logic [31:0]        l1sq_s3, l2sq_s3, l1l2_s3;
	logic [33:0]        a0l1_s3;
	div_t               div_s4 [2];
	logic signed [31:0] c_s36 [2];
	logic [30:0]        cabs_s36 [2];
	sqrt_t              sq_s37 [2];
	cord_t              cord_s69 [2];
	logic [15:0]        ac_sn [2];
	logic signed [17:0] hip_q;
	logic [15:0]        knee_q;
	logic signed [18:0] ankle_q;
	logic               flag_q;

	div_t  div_w [2][DIV_STEPS];
	sqrt_t sq_w [2][SQRT_STEPS];
	cord_t cord_w [2][CORDIC_STAGES];

	logic signed [18:0] rmax, rc, wrap, d2;
	logic signed [16:0] alpha_adj;
	logic signed [37:0] num [2];
	logic [36:0]        mag [2];
	logic [34:0]        den [2];
	logic               sat [2];
	logic signed [19:0] t1_w;
	logic [15:0]        t2_w;
	logic signed [20:0] t3_w;

	function automatic logic [15:0] angle_round(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] c;
		logic signed [ANG_W-1:0] s;
		c = a;
		if (c < 0) c = '0;
		if (c > TOP) c = TOP;
		s = (c + RND) >>> (ANG_BITS - FRAC_BITS);
		return s[15:0];
	endfunction

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_q[NST-1];
	assign hip_angle = hip_q;
	assign knee_angle = knee_q;
	assign ankle_angle = ankle_q;
	assign out_of_reach = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= '0;
			l2_q <= '0;
			l3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_LINK: l1_q <= cfg_data;
				REG_SECOND_LINK: l2_q <= cfg_data;
				REG_THIRD_LINK: l3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NST-2:0], in_valid};
		end
	end

	always_comb begin
		rmax = $signed({3'b0, l1_q}) + $signed({3'b0, l2_q}) + $signed({3'b0, l3_q}) - TENTH;
		rc = $signed({3'b0, foot_radius});
		if (rc > rmax) rc = rmax;
		if (rc < RMIN) rc = RMIN;
		wrap = 19'(foot_angle);
		if (wrap > HALF) wrap = wrap - FULL;
		else if (wrap < -HALF) wrap = wrap + FULL;
		d2 = $signed({1'b0, rc_s1}) - $signed({3'b0, l3_q});
		alpha_adj = side_q[0].alpha;
		if (d2 < 0) begin
			alpha_adj = (side_q[0].alpha > 0) ? 17'(side_q[0].alpha - HALF)
				: 17'(side_q[0].alpha + HALF);
		end else if (d2 == 0) begin
			alpha_adj = '0;
		end
		num[0] = $signed({2'b0, a0sq_s3}) + $signed({6'b0, l1sq_s3}) - $signed({6'b0, l2sq_s3});
		num[1] = $signed({6'b0, l1sq_s3}) + $signed({6'b0, l2sq_s3}) - $signed({2'b0, a0sq_s3});
		den[0] = {a0l1_s3, 1'b0};
		den[1] = {2'b0, l1l2_s3, 1'b0};
		for (int l = 0; l < 2; l++) begin
			mag[l] = num[l][37] ? 37'(-num[l]) : num[l][36:0];
			sat[l] = (den[l] == '0) || (mag[l] > {2'b0, den[l]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rc_s1 <= rc[17:0];
			side_q[0].alpha <= wrap[16:0];
			side_q[0].phi <= foot_angle;
			side_q[0].flag <= 1'b0;
			for (int i = 1; i < SIDE_LEN; i++) begin
				if (i == 1) begin
					side_q[i] <= side_t'{alpha: alpha_adj, phi: side_q[0].phi,
						flag: side_q[0].flag};
				end else if (i == 3) begin
					side_q[i] <= side_t'{alpha: side_q[2].alpha, phi: side_q[2].phi,
						flag: sat[0] || sat[1]};
				end else begin
					side_q[i] <= side_q[i-1];
				end
			end
			a0_s2 <= d2[18] ? 18'(-d2) : d2[17:0];
			a0sq_s3 <= a0_s2 * a0_s2;
			l1sq_s3 <= l1_q * l1_q;
			l2sq_s3 <= l2_q * l2_q;
			a0l1_s3 <= a0_s2 * l1_q;
			l1l2_s3 <= l1_q * l2_q;
			for (int l = 0; l < 2; l++) begin
				div_s4[l].rem <= sat[l] ? '0 : {1'b0, mag[l]};
				div_s4[l].den <= {3'b0, den[l]};
				div_s4[l].q <= '0;
				div_s4[l].neg <= num[l][37];
				div_s4[l].sat <= sat[l];
				if (div_w[l][DIV_STEPS-1].sat) begin
					cabs_s36[l] <= Q_ONE;
					c_s36[l] <= div_w[l][DIV_STEPS-1].neg ? -$signed({1'b0, Q_ONE})
						: $signed({1'b0, Q_ONE});
				end else begin
					cabs_s36[l] <= div_w[l][DIV_STEPS-1].q;
					c_s36[l] <= div_w[l][DIV_STEPS-1].neg
						? -$signed({1'b0, div_w[l][DIV_STEPS-1].q})
						: $signed({1'b0, div_w[l][DIV_STEPS-1].q});
				end
				sq_s37[l].n <= (ROOT_W'(1) << 60) - ROOT_W'(cabs_s36[l] * cabs_s36[l]);
				sq_s37[l].res <= '0;
				sq_s37[l].c <= c_s36[l];
				if (sq_w[l][SQRT_STEPS-1].c < 0) begin
					cord_s69[l].x <= $signed({3'b0, sq_w[l][SQRT_STEPS-1].res[30:0]});
					cord_s69[l].y <= -XY_W'(sq_w[l][SQRT_STEPS-1].c);
					cord_s69[l].ang <= ANG_W'(90) <<< ANG_BITS;
				end else begin
					cord_s69[l].x <= XY_W'(sq_w[l][SQRT_STEPS-1].c);
					cord_s69[l].y <= $signed({3'b0, sq_w[l][SQRT_STEPS-1].res[30:0]});
					cord_s69[l].ang <= '0;
				end
				ac_sn[l] <= angle_round(cord_w[l][CORDIC_STAGES-1].ang);
			end
			hip_q <= t1_w[17:0];
			knee_q <= t2_w;
			ankle_q <= t3_w[18:0];
			flag_q <= side_q[ST_E].flag;
		end
	end

	always_comb begin
		t1_w = -($signed({4'b0, ac_sn[0]}) + 20'(side_q[ST_E].alpha));
		t2_w = 16'(HALF) - ac_sn[1];
		t3_w = -21'(side_q[ST_E].phi) - 21'(t1_w) - $signed({5'b0, t2_w});
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
			if (k == 0) begin : g_first
				tlik_div_cell #(.FIRST(1'b1)) u_cell (
					.clk(clk), .en(adv), .d(div_s4[l]), .q(div_w[l][k])
				);
			end else begin : g_next
				tlik_div_cell #(.FIRST(1'b0)) u_cell (
					.clk(clk), .en(adv), .d(div_w[l][k-1]), .q(div_w[l][k])
				);
			end
		end
		for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
			if (k == 0) begin : g_first
				tlik_sqrt_cell #(.SHIFT(60)) u_cell (
					.clk(clk), .en(adv), .d(sq_s37[l]), .q(sq_w[l][k])
				);
			end else begin : g_next
				tlik_sqrt_cell #(.SHIFT(60 - 2 * k)) u_cell (
					.clk(clk), .en(adv), .d(sq_w[l][k-1]), .q(sq_w[l][k])
				);
			end
		end
		for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cord
			if (k == 0) begin : g_first
				tlik_cordic_cell #(.IDX(0)) u_cell (
					.clk(clk), .en(adv), .d(cord_s69[l]), .q(cord_w[l][k])
				);
			end else begin : g_next
				tlik_cordic_cell #(.IDX(k)) u_cell (
					.clk(clk), .en(adv), .d(cord_w[l][k-1]), .q(cord_w[l][k])
				);
			end
		end
	end
endmodule

// File: design/tlik_div_cell.sv
module tlik_div_cell import tlik_pkg::*; #(
	parameter bit FIRST = 1'b0
) (
	input  logic clk,
	input  logic en,
	input  div_t d,
	output div_t q
);
	logic [REM_W-1:0] sh;
	logic             ge;

	always_comb begin
		sh = FIRST ? d.rem : {d.rem[REM_W-2:0], 1'b0};
		ge = sh >= d.den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= ge ? sh - d.den : sh;
			q.den <= d.den;
			q.q   <= {d.q[DIV_STEPS-2:0], ge};
			q.neg <= d.neg;
			q.sat <= d.sat;
		end
	end
endmodule

// File: design/tlik_sqrt_cell.sv
module tlik_sqrt_cell import tlik_pkg::*; #(
	parameter int SHIFT = 60
) (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d,
	output sqrt_t q
);
	localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << SHIFT;

	logic [ROOT_W-1:0] trial;
	logic              ge;

	always_comb begin
		trial = d.res + BIT;
		ge = d.n >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.n   <= ge ? d.n - trial : d.n;
			q.res <= ge ? (d.res >> 1) + BIT : d.res >> 1;
			q.c   <= d.c;
		end
	end
endmodule

// File: design/tlik_cordic_cell.sv
module tlik_cordic_cell import tlik_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  en,
	input  cord_t d,
	output cord_t q
);
	localparam logic signed [ANG_W-1:0] STEP = atan_deg(IDX);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;

	always_comb begin
		xs = d.x >>> IDX;
		ys = d.y >>> IDX;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d.y > 0) begin
				q.x   <= d.x + ys;
				q.y   <= d.y - xs;
				q.ang <= d.ang + STEP;
			end else begin
				q.x   <= d.x - ys;
				q.y   <= d.y + xs;
				q.ang <= d.ang - STEP;
			end
		end
	end
endmodule

// File: design/tlik_checker.sv
module tlik_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        knee_angle
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while the output is blocked");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with nothing waiting at the output");

	a_knee_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> knee_angle <= 16'd46080)
		else $error("knee angle beyond a half turn");
endmodule

bind three_link_planar_ik tlik_checker u_tlik_checker (.*);

// File: tb/tb_three_link_planar_ik.sv
`timescale 1ns / 1ps

module tb_three_link_planar_ik;
	import tlik_pkg::*;

	typedef struct {
		logic signed [17:0] hip;
		logic [15:0]        knee;
		logic signed [18:0] ankle;
		logic               reach;
	} joint_set_t;

	typedef struct {
		logic [15:0]        radius;
		logic signed [16:0] angle;
		bit                 typed;
		bit                 reach;
	} plan_row_t;

	localparam int SPLIT_ROW = 8;
	localparam int PLAN_ROWS = 22;
	localparam int RANDOM_ITEMS = 1800;
	localparam int SETTLE_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 600000;
	localparam longint HALF_TURN = 64'sd180 <<< FRAC_BITS;
	localparam longint FULL_TURN = 64'sd360 <<< FRAC_BITS;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [15:0] foot_radius;
	logic signed [16:0] foot_angle;
	logic out_valid;
	logic out_stall;
	logic signed [17:0] hip_angle;
	logic [15:0] knee_angle;
	logic signed [18:0] ankle_angle;
	logic out_of_reach;

	longint link_len [3];
	longint atan_steps [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};
	joint_set_t pending_joints[$];
	plan_row_t plan [PLAN_ROWS];
	int mismatches;
	int beats_in;
	int beats_out;
	int reach_flags;
	int link_settings;
	longint cycles;
	int stall_mode;

	three_link_planar_ik i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.foot_radius(foot_radius),
		.foot_angle(foot_angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hip_angle(hip_angle),
		.knee_angle(knee_angle),
		.ankle_angle(ankle_angle),
		.out_of_reach(out_of_reach)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint cosine_q30(longint num, longint den, inout bit flag);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? -num : num;
		if (den <= 0 || mag > den) begin
			flag = 1'b1;
			return (num < 0) ? -(64'sd1 <<< 30) : (64'sd1 <<< 30);
		end
		q = (mag << 30) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint arc_cos_deg(longint c);
		longint unsigned cm;
		longint x, y, ang, nx, ny, t;
		cm = (c < 0) ? -c : c;
		x = c;
		y = longint'(root_floor((64'd1 << 60) - cm * cm));
		ang = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			ang = 64'sd90 <<< ANG_BITS;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF && i < CORDIC_MAX; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				ang += atan_steps[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				ang -= atan_steps[i];
			end
			x = nx;
			y = ny;
		end
		if (ang < 0)
			ang = 0;
		if (ang > (64'sd180 <<< ANG_BITS))
			ang = 64'sd180 <<< ANG_BITS;
		return (ang + (64'sd1 <<< (ANG_BITS - 1 - FRAC_BITS))) >>> (ANG_BITS - FRAC_BITS);
	endfunction

	function automatic joint_set_t solve_leg(logic [15:0] radius, logic signed [16:0] angle);
		joint_set_t js;
		longint l1, l2, l3, r, phi, rmax, d, a0, alpha, c1, c2, t1, t2, t3;
		bit flag;
		l1 = link_len[0];
		l2 = link_len[1];
		l3 = link_len[2];
		r = longint'(radius);
		phi = longint'(angle);
		flag = 1'b0;
		rmax = l1 + l2 + l3 - ((64'sd1 <<< FRAC_BITS) + 5) / 10;
		if (r > rmax)
			r = rmax;
		if (r < (64'sd10 <<< FRAC_BITS))
			r = 64'sd10 <<< FRAC_BITS;
		d = r - l3;
		a0 = (d < 0) ? -d : d;
		alpha = phi;
		while (alpha > HALF_TURN)
			alpha -= FULL_TURN;
		while (alpha < -HALF_TURN)
			alpha += FULL_TURN;
		if (d < 0)
			alpha = (alpha > 0) ? alpha - HALF_TURN : alpha + HALF_TURN;
		else if (d == 0)
			alpha = 0;
		c1 = cosine_q30(a0 * a0 + l1 * l1 - l2 * l2, 2 * a0 * l1, flag);
		c2 = cosine_q30(l1 * l1 + l2 * l2 - a0 * a0, 2 * l1 * l2, flag);
		t1 = -(arc_cos_deg(c1) + alpha);
		t2 = HALF_TURN - arc_cos_deg(c2);
		t3 = -phi - t1 - t2;
		js.hip = t1[17:0];
		js.knee = t2[15:0];
		js.ankle = t3[18:0];
		js.reach = flag;
		return js;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		joint_set_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycles, pending_joints.size());
			$display("tb_three_link_planar_ik failed");
			$finish;
		end
		if (arst_n && in_valid && !in_stall) begin
			pending_joints.push_back(solve_leg(foot_radius, foot_angle));
			beats_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (pending_joints.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				want = pending_joints.pop_front();
				reach_flags += int'(want.reach);
				if (hip_angle !== want.hip)
					report_mismatch("hip_angle", longint'(hip_angle), longint'(want.hip));
				if (knee_angle !== want.knee)
					report_mismatch("knee_angle", longint'(knee_angle), longint'(want.knee));
				if (ankle_angle !== want.ankle)
					report_mismatch("ankle_angle", longint'(ankle_angle),
						longint'(want.ankle));
				if (out_of_reach !== want.reach)
					report_mismatch("out_of_reach", longint'(out_of_reach),
						longint'(want.reach));
			end
		end
	end

	// The receiver switches between stall densities so that some stretches never stall.
	initial begin
		stall_mode = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 3);
			out_stall <= (stall_mode != 0) && ($urandom_range(0, 3) < stall_mode);
		end
	end

	task automatic send_foot(logic [15:0] radius, logic signed [16:0] angle);
		foot_radius <= radius;
		foot_angle <= angle;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic pause_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic set_links(logic [15:0] first, logic [15:0] second, logic [15:0] third);
		logic [15:0] vals [3];
		reg_index_t idx [3];
		vals = '{first, second, third};
		idx = '{REG_FIRST_LINK, REG_SECOND_LINK, REG_THIRD_LINK};
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_joints.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(negedge clk);
			link_len[i] = longint'(vals[i]);
		end
		cfg_we <= 1'b0;
		link_settings++;
	endtask

	task automatic random_phase(int count, int reach_span);
		int burst;
		int sent;
		logic [15:0] radius;
		logic signed [16:0] angle;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && sent < count; b++) begin
				if ($urandom_range(0, 9) < 7) begin
					radius = 16'($urandom_range(0, reach_span));
					angle = $signed(17'($urandom_range(0, 92160))) - 17'sd46080;
				end else begin
					radius = 16'($urandom);
					angle = 17'($urandom);
				end
				send_foot(radius, angle);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin
		joint_set_t typed_check;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		foot_radius = '0;
		foot_angle = '0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		reach_flags = 0;
		link_settings = 1;
		cycles = 0;
		link_len = '{0, 0, 0};
		plan = '{
			'{16'd0, 17'sd0, 1'b1, 1'b1},
			'{16'hFFFF, 17'sd46080, 1'b1, 1'b1},
			'{16'd2560, -17'sd46080, 1'b1, 1'b1},
			'{16'h5555, -17'sd65536, 1'b1, 1'b1},
			'{16'hAAAA, 17'sd65535, 1'b1, 1'b1},
			'{16'd1, 17'sd1, 1'b1, 1'b1},
			'{16'h8000, -17'sd1, 1'b1, 1'b1},
			'{16'd100, 17'sd23040, 1'b1, 1'b1},
			'{16'd0, 17'sd0, 1'b0, 1'b0},
			'{16'd0, 17'sd11520, 1'b0, 1'b0},
			'{16'd5120, 17'sd11520, 1'b0, 1'b0},
			'{16'd5120, -17'sd46080, 1'b0, 1'b0},
			'{16'hFFFF, 17'sd0, 1'b0, 1'b0},
			'{16'hFFFF, 17'sd46080, 1'b0, 1'b0},
			'{16'd25574, -17'sd46080, 1'b0, 1'b0},
			'{16'd20000, 17'sd65535, 1'b0, 1'b0},
			'{16'd20000, -17'sd65536, 1'b0, 1'b0},
			'{16'd12800, 17'sd46081, 1'b0, 1'b0},
			'{16'd3000, -17'sd100, 1'b0, 1'b0},
			'{16'd3000, 17'sd0, 1'b0, 1'b0},
			'{16'd7680, 17'sd30000, 1'b0, 1'b0},
			'{16'h7FFF, -17'sd23040, 1'b0, 1'b0}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (i == SPLIT_ROW)
				set_links(16'd10240, 16'd10240, 16'd5120);
			if (plan[i].typed) begin
				typed_check = solve_leg(plan[i].radius, plan[i].angle);
				if (typed_check.reach !== plan[i].reach)
					report_mismatch("tabled out_of_reach", longint'(typed_check.reach),
						longint'(plan[i].reach));
			end
			send_foot(plan[i].radius, plan[i].angle);
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 4));
		end

		random_phase(RANDOM_ITEMS / 8, 30000);
		set_links(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_phase(RANDOM_ITEMS / 8, 65535);
		set_links(16'd0, 16'd8000, 16'd3000);
		random_phase(RANDOM_ITEMS / 8, 15000);
		set_links(16'd9000, 16'd0, 16'd0);
		random_phase(RANDOM_ITEMS / 8, 12000);
		set_links(16'd20000, 16'd3000, 16'd4000);
		random_phase(RANDOM_ITEMS / 8, 30000);
		for (int k = 0; k < 3; k++) begin
			set_links(16'($urandom_range(256, 40000)), 16'($urandom_range(256, 40000)),
				16'($urandom_range(0, 20000)));
			random_phase(RANDOM_ITEMS / 8, 65535);
		end

		pause_sender(1);
		while (pending_joints.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Solved %0d leg poses over %0d link-length settings, %0d flagged out of reach.",
			beats_out, link_settings, reach_flags);
		$display("Beats in: %0d, mismatches: %0d.", beats_in, mismatches);
		if (mismatches == 0 && pending_joints.size() == 0)
			$display("tb_three_link_planar_ik passed");
		else
			$display("tb_three_link_planar_ik failed");
		$finish;
	end

endmodule
